// ===== sv/r64a_pkg.sv =====
// ----------------------------------------------------------------------------
// r64a_pkg - shared types, constants and functions of the radix-64 encoder
// Word formats, queue entry, CRC-24 step and the character tables.
// ----------------------------------------------------------------------------
package r64a_pkg;

    // Input and output words
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } src_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } dst_word_t;

    // Input item modes
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Job kinds in the queue
    localparam logic JOB_DATA = 1'b0;
    localparam logic JOB_FIN  = 1'b1;

    // One queued job: one or two sextets of a data byte, or a finish sequence
    typedef struct packed {
        logic        kind;
        logic        two;       // data job gives two characters
        logic [5:0]  s0;        // first sextet, or pending sextet of finish
        logic [5:0]  s1;        // second sextet of a data job
        logic [1:0]  phase;     // group phase at finish
        logic [23:0] crc;       // checksum at finish
    } job_t;

    localparam logic [23:0] CRC_INIT = 24'hB704CE;
    localparam logic [23:0] CRC_POLY = 24'h864CFB;  // x^24 term implied

    localparam int          QUEUE_DEPTH = 2;

    // Positions in the finish sequence
    localparam logic [5:0] POS_PAD1  = 6'd1;
    localparam logic [5:0] POS_PAD2  = 6'd2;
    localparam logic [5:0] POS_CR    = 6'd3;
    localparam logic [5:0] POS_LF    = 6'd4;
    localparam logic [5:0] POS_EQ    = 6'd5;
    localparam logic [5:0] POS_CRC0  = 6'd6;
    localparam logic [5:0] POS_CRC1  = 6'd7;
    localparam logic [5:0] POS_CRC2  = 6'd8;
    localparam logic [5:0] POS_CRC3  = 6'd9;
    localparam logic [5:0] POS_TRAIL = 6'd10;
    localparam logic [5:0] POS_LAST  = 6'd40;

    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_EQ = 8'h3D;

    function automatic logic [23:0] crc_step(input logic [23:0] crc_in,
                                             input logic [7:0]  b);
        logic [23:0] c;
        c = crc_in ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'h41;
        else if (v < 6'd52)
            return w + 8'h47;           // 'a' - 26
        else if (v < 6'd62)
            return w - 8'h04;           // '0' - 52
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    // Closing trailer line, CR LF on both sides
    function automatic logic [7:0] trailer_char(input logic [4:0] idx);
        case (idx)
            5'd0:  return ASCII_CR;
            5'd1:  return ASCII_LF;
            5'd2, 5'd3, 5'd4, 5'd5, 5'd6: return 8'h2D;
            5'd7:  return 8'h45;
            5'd8:  return 8'h4E;
            5'd9:  return 8'h44;
            5'd10: return 8'h20;
            5'd11: return 8'h50;
            5'd12: return 8'h47;
            5'd13: return 8'h50;
            5'd14: return 8'h20;
            5'd15: return 8'h53;
            5'd16: return 8'h49;
            5'd17: return 8'h47;
            5'd18: return 8'h4E;
            5'd19: return 8'h41;
            5'd20: return 8'h54;
            5'd21: return 8'h55;
            5'd22: return 8'h52;
            5'd23: return 8'h45;
            5'd24, 5'd25, 5'd26, 5'd27, 5'd28: return 8'h2D;
            5'd29: return ASCII_CR;
            5'd30: return ASCII_LF;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [5:0] start_pos(input job_t j);
        if (j.kind == JOB_FIN && j.phase == 2'd0)
            return POS_CR;
        else
            return 6'd0;
    endfunction

    function automatic logic is_last(input job_t j, input logic [5:0] pos);
        if (j.kind == JOB_FIN)
            return pos == POS_LAST;
        else
            return pos == {5'd0, j.two};
    endfunction

    function automatic logic [5:0] next_pos(input job_t j, input logic [5:0] pos);
        if (j.kind == JOB_FIN && j.phase == 2'd2 && pos == POS_PAD1)
            return POS_CR;
        else
            return pos + 6'd1;
    endfunction

    function automatic logic [7:0] char_at(input job_t j, input logic [5:0] pos);
        logic [5:0] t;
        t = pos - POS_TRAIL;
        if (j.kind == JOB_DATA)
            return pos[0] ? b64_char(j.s1) : b64_char(j.s0);
        case (pos)
            6'd0:     return b64_char(j.s0);
            POS_PAD1: return ASCII_EQ;
            POS_PAD2: return ASCII_EQ;
            POS_CR:   return ASCII_CR;
            POS_LF:   return ASCII_LF;
            POS_EQ:   return ASCII_EQ;
            POS_CRC0: return b64_char(j.crc[23:18]);
            POS_CRC1: return b64_char(j.crc[17:12]);
            POS_CRC2: return b64_char(j.crc[11:6]);
            POS_CRC3: return b64_char(j.crc[5:0]);
            default:  return trailer_char(t[4:0]);
        endcase
    endfunction

endpackage

// ===== sv/r64a_front.sv =====
// ----------------------------------------------------------------------------
// r64a_front - input side of the radix-64 encoder
// Accepts words, updates CRC, phase and carry, and queues one job per word.
// ----------------------------------------------------------------------------
module r64a_front
    import r64a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_word_t src,
    input  logic      q_full,
    output logic      q_push,
    output job_t      q_job
);

    logic [23:0] crc_reg,   crc_next;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  carry_reg, carry_next;
    logic [1:0]  ph;

    assign src_stall = q_full;
    assign q_push    = src_valid && !q_full;
    // phase 3 is unreachable; treat it as a group boundary
    assign ph        = (phase_reg == 2'd3) ? 2'd0 : phase_reg;

    always_comb
    begin
        crc_next   = crc_reg;
        phase_next = phase_reg;
        carry_next = carry_reg;
        q_job      = '0;
        q_job.phase = ph;
        q_job.crc   = crc_reg;
        if (src.mode == MODE_DATA)
        begin
            q_job.kind = JOB_DATA;
            crc_next   = crc_step(crc_reg, src.data_byte);
            case (ph)
                2'd0:
                begin
                    q_job.s0   = src.data_byte[7:2];
                    carry_next = {src.data_byte[1:0], 4'b0000};
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    q_job.s0   = carry_reg | {2'b00, src.data_byte[7:4]};
                    carry_next = {src.data_byte[3:0], 2'b00};
                    phase_next = 2'd2;
                end
                default:
                begin
                    q_job.two  = 1'b1;
                    q_job.s0   = carry_reg | {4'b0000, src.data_byte[7:6]};
                    q_job.s1   = src.data_byte[5:0];
                    carry_next = 6'd0;
                    phase_next = 2'd0;
                end
            endcase
        end
        else
        begin
            // finish: snapshot the checksum, then return to reset values
            q_job.kind = JOB_FIN;
            q_job.s0   = carry_reg;
            crc_next   = CRC_INIT;
            phase_next = 2'd0;
            carry_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            phase_reg <= 2'd0;
            carry_reg <= 6'd0;
        end
        else if (q_push)
        begin
            crc_reg   <= crc_next;
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== sv/r64a_queue.sv =====
// ----------------------------------------------------------------------------
// r64a_queue - two-entry job queue between front and back
// Lets the input side run ahead while the output side is stalled.
// ----------------------------------------------------------------------------
module r64a_queue
    import r64a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full       = count_reg == 2'(QUEUE_DEPTH);
    assign head_valid = count_reg != 2'd0;
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/r64a_back.sv =====
// ----------------------------------------------------------------------------
// r64a_back - output side of the radix-64 encoder
// Expands jobs into characters at an output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module r64a_back
    import r64a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      dst_valid,
    input  logic      dst_stall,
    output dst_word_t dst
);

    logic       busy_reg, busy_next;
    job_t       job_reg,  job_next;
    logic [5:0] pos_reg,  pos_next;
    logic       dvalid_reg, dvalid_next;
    dst_word_t  dword_reg,  dword_next;

    job_t       cur_job;
    logic [5:0] cur_pos;
    logic       have_src;
    logic       advance;
    logic       fire;
    logic       cur_last;

    // work from the held job, else straight from the queue head
    assign cur_job  = busy_reg ? job_reg : head_job;
    assign cur_pos  = busy_reg ? pos_reg : start_pos(head_job);
    assign have_src = busy_reg || head_valid;
    assign advance  = !dvalid_reg || !dst_stall;
    assign fire     = advance && have_src;
    assign pop      = fire && !busy_reg;
    assign cur_last = is_last(cur_job, cur_pos);

    assign dst_valid = dvalid_reg;
    assign dst       = dword_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        job_next    = job_reg;
        pos_next    = pos_reg;
        dvalid_next = dvalid_reg;
        dword_next  = dword_reg;
        if (advance)
            dvalid_next = have_src;
        if (fire)
        begin
            dword_next.out_char = char_at(cur_job, cur_pos);
            dword_next.last     = cur_last;
            busy_next           = !cur_last;
            job_next            = cur_job;
            pos_next            = next_pos(cur_job, cur_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            dvalid_reg <= dvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pos_reg   <= pos_next;
        dword_reg <= dword_next;
    end

endmodule

// ===== sv/radix64_armor_encoder_crc24_top.sv =====
// ----------------------------------------------------------------------------
// radix64_armor_encoder_crc24_top - radix-64 armor encoder with CRC-24 trailer
// Encodes a byte stream to base64 characters and closes each message with
// padding, the checksum line and a fixed trailer line.
// ----------------------------------------------------------------------------
//
//  channel | direction | word       | handshake
//  --------+-----------+------------+--------------------------------------
//  src     | in        | src_word_t | src_valid, src_stall (driven here)
//  dst     | out       | dst_word_t | dst_valid, dst_stall (driven outside)
//
//  A data word gives the output stage one character at group phase 0 or 1
//  and two at phase 2; a finish word gives 38, 40 or 41 characters. The
//  single output register sends one character per cycle while dst_stall
//  is low.
//  Reset clears the queue, the output register valid, the CRC (to its init
//  value), the phase and the carry. A stall at the output holds the current
//  word; the two-entry queue keeps taking input words until it fills.
//
module radix64_armor_encoder_crc24_top
    import r64a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_word_t src,
    output logic      dst_valid,
    input  logic      dst_stall,
    output dst_word_t dst
);

    // Front-to-queue and queue-to-back job traffic
    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_head_valid;
    job_t q_head_job;

    // Classify each input word, advance CRC and phase, emit one job
    r64a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_push_job)
    );

    // Decouple the two sides
    r64a_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // Expand each job into characters at the output register
    r64a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst        (dst)
    );

endmodule

// ===== verif/tb_radix64_armor_encoder_crc24_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix64_armor_encoder_crc24_top - self-checking bench for the armor encoder
// Streams data and finish words through the encoder with random sender gaps
// and receiver stalls. A local model of the encoder (base64 grouping, CRC-24,
// padding, checksum line and trailer) predicts every output character.
// Each output word is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_radix64_armor_encoder_crc24_top;
    import r64a_pkg::*;

    localparam int    QUIET_LIMIT  = 3000;  // cycles with no word moving on either side
    localparam int    HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int    DRAIN_CYCLES = 20;    // settle time after the last character
    localparam int    RANDOM_WORDS = 120;

    localparam string B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam string TAIL_HEAD = "-----END ";
    localparam string TAIL_BODY = " SIGNATURE-----";

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_word_t src       = '0;
    logic      dst_valid;
    logic      dst_stall = 1'b0;
    dst_word_t dst;

    // Model state of the encoder
    logic [23:0] crc_acc;
    logic [1:0]  grp_phase;
    logic [5:0]  carry_sx;

    // Characters still owed by the encoder, oldest first
    dst_word_t   pending_chars[$];

    int          err_cnt     = 0;
    int          quiet_cnt   = 0;
    int          burst_left  = 0;
    bit          steady_src  = 1'b0;
    bit          hold_req    = 1'b0;
    int          words_sent  = 0;

    radix64_armor_encoder_crc24_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst       (dst)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // One byte through the CRC-24 register, MSB first, full 25-bit polynomial
    function automatic logic [23:0] crc24_next(input logic [23:0] c, input logic [7:0] b);
        logic [24:0] r;
        r = {1'b0, c ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++)
        begin
            r = r << 1;
            if (r[24])
                r = r ^ 25'h1864CFB;
        end
        return r[23:0];
    endfunction

    function automatic void owe_char(input logic [7:0] ch);
        dst_word_t w;
        w.out_char = ch;
        w.last     = 1'b0;
        pending_chars.insert(pending_chars.size(), w);
    endfunction

    function automatic void owe_sextet(input logic [5:0] v);
        owe_char(B64_SET[v]);
    endfunction

    function automatic void armor_reset();
        crc_acc   = CRC_INIT;
        grp_phase = 2'd0;
        carry_sx  = 6'd0;
    endfunction

    // Append the characters one accepted word must produce
    function automatic void armor_predict(input logic m, input logic [7:0] b);
        logic [1:0] ph;
        ph = (grp_phase == 2'd3) ? 2'd0 : grp_phase;
        if (m == MODE_DATA)
        begin
            crc_acc = crc24_next(crc_acc, b);
            case (ph)
                2'd0:
                begin
                    owe_sextet(b[7:2]);
                    carry_sx  = {b[1:0], 4'h0};
                    grp_phase = 2'd1;
                end
                2'd1:
                begin
                    owe_sextet(carry_sx | {2'b00, b[7:4]});
                    carry_sx  = {b[3:0], 2'b00};
                    grp_phase = 2'd2;
                end
                default:
                begin
                    owe_sextet(carry_sx | {4'h0, b[7:6]});
                    owe_sextet(b[5:0]);
                    carry_sx  = 6'd0;
                    grp_phase = 2'd0;
                end
            endcase
        end
        else
        begin
            // flush the open group with its padding
            if (ph != 2'd0)
            begin
                owe_sextet(carry_sx);
                owe_char(ASCII_EQ);
                if (ph == 2'd1)
                    owe_char(ASCII_EQ);
            end
            owe_char(ASCII_CR);
            owe_char(ASCII_LF);
            owe_char(ASCII_EQ);
            owe_sextet(crc_acc[23:18]);
            owe_sextet(crc_acc[17:12]);
            owe_sextet(crc_acc[11:6]);
            owe_sextet(crc_acc[5:0]);
            // closing line; the three-letter tag is spelled out as bytes
            owe_char(ASCII_CR);
            owe_char(ASCII_LF);
            for (int i = 0; i < TAIL_HEAD.len(); i++)
                owe_char(TAIL_HEAD[i]);
            owe_char(8'h50);
            owe_char(8'h47);
            owe_char(8'h50);
            for (int i = 0; i < TAIL_BODY.len(); i++)
                owe_char(TAIL_BODY[i]);
            owe_char(ASCII_CR);
            owe_char(ASCII_LF);
            armor_reset();
        end
        pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, unless steady_src
    // ------------------------------------------------------------------------
    task automatic send_word(input logic m, input logic [7:0] b);
        int gap;
        gap = 0;
        if (!steady_src)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                gap        = $urandom_range(1, 6);
            end
            burst_left--;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            // drop valid for the gap, then offer the word
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid      <= 1'b1;
        src.mode       <= m;
        src.data_byte  <= b;
        // hold the word until the encoder takes it
        forever
        begin
            @(posedge clk);
            if (!src_stall)
                break;
        end
        armor_predict(m, b);
        words_sent++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_word(MODE_DATA, b);
    endtask

    task automatic send_finish();
        send_word(MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int  rx_mode;
        int  rx_left;
        int  hold_cnt;
        bit  stall_nxt;
        rx_mode  = 0;
        rx_left  = 0;
        hold_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                stall_nxt = 1'b1;
            end
            else
            begin
                case (rx_mode)
                    0:       stall_nxt = 1'b0;                          // free flow
                    1:       stall_nxt = ($urandom_range(0, 3) == 0);   // light
                    2:       stall_nxt = ($urandom_range(0, 9) < 7);    // heavy
                    default: stall_nxt = ~dst_stall;                    // alternate
                endcase
            end
            dst_stall <= stall_nxt;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every output word against the oldest owed character
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        dst_word_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected word: expected none, actual char=%h last=%b",
                         $time, dst.out_char, dst.last);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (dst.out_char !== want.out_char || dst.last !== want.last)
                begin
                    err_cnt++;
                    $display("%0t: mismatch: expected char=%h last=%b, actual char=%h last=%b",
                             $time, want.out_char, want.last, dst.out_char, dst.last);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt == QUIET_LIMIT)
        begin
            $display("tb_radix64_armor_encoder_crc24_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Byte extremes and a finish at each group phase, empty message included
    task automatic test_directed();
        send_finish();                  // empty message, finish at group boundary
        send_data(8'h00);
        send_data(8'hFF);               // phase 2: one padding character
        send_finish();
        send_data(8'hFF);               // phase 1: two padding characters
        send_finish();
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h80);               // full group, no padding
        send_word(MODE_FINISH, 8'hFF);  // data field ignored on finish
        for (int i = 0; i < 8; i++)
            send_data(8'(1 << i));
        send_data(8'hAA);
        send_data(8'h55);
        send_word(MODE_FINISH, 8'h00);
    endtask

    // Messages of random length with random content, each closed by a finish
    task automatic test_random_messages();
        int len;
        int pick;
        while (words_sent < RANDOM_WORDS)
        begin
            len        = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(1, 14);
            steady_src = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    send_data(8'h00);
                else if (pick == 1)
                    send_data(8'hFF);
                else
                    send_data(8'($urandom_range(0, 255)));
            end
            send_finish();
        end
        steady_src = 1'b0;
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure();
        steady_src = 1'b1;
        hold_req   = 1'b1;
        for (int i = 0; i < 16; i++)
            send_data(8'($urandom_range(0, 255)));
        send_finish();
        steady_src = 1'b0;
    endtask

    initial
    begin
        armor_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_messages();

        // release the input and drain every owed character
        @(negedge clk);
        src_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("tb_radix64_armor_encoder_crc24_top OK");
        else
            $display("tb_radix64_armor_encoder_crc24_top NOT OK");
        $finish;
    end

endmodule
